// File: sv/smmgt_pkg.sv
// Shared types, constants and codes of the span min/max gap tracker.
package smmgt_pkg;

  // Field widths fixed by the item format.
  localparam int VAL_W = 32;
  localparam int CNT_W = 11;

  // Default number of entries in the value store.
  localparam int STORE_DEPTH_DEF = 1024;

  // Flipping the sign bit makes unsigned order equal signed order.
  localparam logic [VAL_W-1:0] SIGN_BIAS = 32'h8000_0000;

  // Acceptance status of an item.
  typedef enum logic {
    ADD_STORED = 1'b0,
    ADD_FULL   = 1'b1
  } add_status_t;

  // Validity of the reported spans.
  typedef enum logic [1:0] {
    SPAN_VALID = 2'd0,
    SPAN_NONE  = 2'd1,
    SPAN_ONE   = 2'd2
  } span_status_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_UPDATE,
    S_RESULT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the new item and clear the scan index
    logic rd;      // read the store at the scan index and advance it
    logic commit;  // write the item into the store, update min, max and count
    logic emit;    // load the output register with the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;       // count has reached the effective capacity
    logic empty;      // no values held
    logic scan_last;  // scan index points at the last held value
    logic out_free;   // output register can take a new result
  } status_t;

endpackage

// File: sv/smmgt_if.sv
// Channel interfaces of the span min/max gap tracker: input, result and configuration.
interface smmgt_in_if import smmgt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] new_value;

  modport source (output valid, output new_value, input ready);
  modport sink (input valid, input new_value, output ready);
endinterface

interface smmgt_out_if import smmgt_pkg::*; ();
  logic              valid;
  logic              ready;
  add_status_t       add_status;
  logic [CNT_W-1:0]  stored_count;
  span_status_t      span_status;
  logic [VAL_W-1:0]  longest_span;
  logic [VAL_W-1:0]  shortest_span;

  modport source (output valid, output add_status, output stored_count,
                  output span_status, output longest_span, output shortest_span,
                  input ready);
  modport sink (input valid, input add_status, input stored_count,
                input span_status, input longest_span, input shortest_span,
                output ready);
endinterface

interface smmgt_cfg_if import smmgt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] capacity;

  modport source (output valid, output capacity, input ready);
  modport sink (input valid, input capacity, output ready);
endinterface

// File: sv/smmgt_datapath.sv
// Datapath of the span min/max gap tracker: value store, scan compare, running state, output register.
module smmgt_datapath import smmgt_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  output status_t                 sts,
  input  logic signed [VAL_W-1:0] in_new_value,
  input  logic                    cfg_valid,
  input  logic [CNT_W-1:0]        cfg_capacity,
  input  logic                    out_ready,
  output logic                    out_valid,
  output add_status_t             out_add_status,
  output logic [CNT_W-1:0]        out_stored_count,
  output span_status_t            out_span_status,
  output logic [VAL_W-1:0]        out_longest_span,
  output logic [VAL_W-1:0]        out_shortest_span
);

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int IW = (AW > CNT_W) ? AW : CNT_W;
  localparam logic [31:0] DEPTH_W = 32'(STORE_DEPTH);

  logic [VAL_W-1:0] mem [STORE_DEPTH];

  logic [CNT_W-1:0] capacity_r;
  logic [CNT_W-1:0] count_r;
  logic [VAL_W-1:0] min_r;
  logic [VAL_W-1:0] max_r;
  logic [VAL_W-1:0] gap_r;
  logic [VAL_W-1:0] val_r;
  logic             reject_r;
  logic [CNT_W-1:0] scan_idx_r;
  logic             rd_pend_r;
  logic [VAL_W-1:0] rd_data_r;
  logic             out_valid_r;
  add_status_t      out_add_status_r;
  logic [CNT_W-1:0] out_count_r;
  span_status_t     out_span_status_r;
  logic [VAL_W-1:0] out_longest_r;
  logic [VAL_W-1:0] out_shortest_r;

  logic [IW-1:0]    scan_wide;
  logic [IW-1:0]    wr_wide;
  logic [AW-1:0]    scan_addr;
  logic [AW-1:0]    wr_addr;
  logic             full;
  logic             val_ge;
  logic [VAL_W-1:0] diff_abs;

  // Store addresses from the scan index and the fill count.
  assign scan_wide = IW'(scan_idx_r);
  assign wr_wide   = IW'(count_r);
  assign scan_addr = scan_wide[AW-1:0];
  assign wr_addr   = wr_wide[AW-1:0];

  // Full once the count reaches the capacity or the store depth.
  assign full = (count_r >= capacity_r) || (32'(count_r) >= DEPTH_W);

  // Status to the controller.
  always_comb begin
    sts.full      = full;
    sts.empty     = (count_r == '0);
    sts.scan_last = (scan_idx_r == (count_r - CNT_W'(1)));
    sts.out_free  = !out_valid_r || out_ready;
  end

  // Capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= '0;
    end else if (cfg_valid) begin
      capacity_r <= cfg_capacity;
    end
  end

  // Item capture and scan index.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r    <= VAL_W'(in_new_value) ^ SIGN_BIAS;
      reject_r <= full;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      rd_pend_r  <= 1'b0;
    end else begin
      rd_pend_r <= cmd.rd;
      if (cmd.load) begin
        scan_idx_r <= '0;
      end else if (cmd.rd) begin
        scan_idx_r <= scan_idx_r + CNT_W'(1);
      end
    end
  end

  // Value store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      mem[wr_addr] <= val_r;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[scan_addr];
    end
  end

  // Exact distance between the new value and the value just read.
  assign val_ge   = (val_r >= rd_data_r);
  assign diff_abs = val_ge ? (val_r - rd_data_r) : (rd_data_r - val_r);

  // Running gap, minimum, maximum and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      min_r   <= '0;
      max_r   <= '0;
      gap_r   <= '1;
    end else begin
      if (rd_pend_r && (diff_abs < gap_r)) begin
        gap_r <= diff_abs;
      end
      if (cmd.commit) begin
        count_r <= count_r + CNT_W'(1);
        if (count_r == '0) begin
          min_r <= val_r;
          max_r <= val_r;
        end else begin
          if (val_r < min_r) begin
            min_r <= val_r;
          end
          if (val_r > max_r) begin
            max_r <= val_r;
          end
        end
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result fields, taken from the state after the item.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_add_status_r <= reject_r ? ADD_FULL : ADD_STORED;
      out_count_r      <= count_r;
      if (count_r == '0) begin
        out_span_status_r <= SPAN_NONE;
        out_longest_r     <= '0;
        out_shortest_r    <= '0;
      end else if (count_r == CNT_W'(1)) begin
        out_span_status_r <= SPAN_ONE;
        out_longest_r     <= '0;
        out_shortest_r    <= '0;
      end else begin
        out_span_status_r <= SPAN_VALID;
        out_longest_r     <= max_r - min_r;
        out_shortest_r    <= gap_r;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_add_status    = out_add_status_r;
  assign out_stored_count  = out_count_r;
  assign out_span_status   = out_span_status_r;
  assign out_longest_span  = out_longest_r;
  assign out_shortest_span = out_shortest_r;

`ifndef SYNTH
  // The fill count never passes the store depth.
  a_count_depth: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= DEPTH_W)
    else $error("count exceeds store depth");

  // A value is only written into the store when there is room for it.
  a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !full)
    else $error("store written while full");

  // A result is never loaded over one that has not been taken.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result overwritten");

  // Minimum and maximum stay ordered while values are held.
  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> (min_r <= max_r))
    else $error("minimum above maximum");

  // Reads stay inside the held values.
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |-> (scan_idx_r < count_r))
    else $error("scan read beyond held values");
`endif

endmodule

// File: sv/smmgt_ctrl.sv
// Controller state machine of the span min/max gap tracker.
module smmgt_ctrl import smmgt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (sts.full) begin
            state_nxt = S_RESULT;
          end else if (sts.empty) begin
            state_nxt = S_UPDATE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SCAN: begin
        cmd.rd = 1'b1;
      end
      S_DRAIN: begin
        // The last read value is compared in this cycle.
      end
      S_UPDATE: begin
        cmd.commit = 1'b1;
      end
      S_RESULT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// File: sv/span_min_max_gap_tracker_unit.sv
// Top level of the span min/max gap tracker: controller, datapath and channel wiring.
//
//   Channel  Dir  Handshake     Payload
//   in_ch    in   valid/ready   new_value (signed 32)
//   out_ch   out  valid/ready   add_status, stored_count, span_status,
//                               longest_span, shortest_span
//   cfg_ch   in   valid/ready   capacity (11 bits), always ready
//
// A stored number is compared with every value already held before the next
// item can be taken; an empty store skips the scan, and a rejected number
// skips both the scan and the store write. The scan is paced by the single
// read port of the value store, which it walks one entry per cycle.
// Reset is synchronous and active low; the store itself is not cleared.
// A result waiting in the output register stalls the block only when the
// next result is ready to be loaded.
module span_min_max_gap_tracker_unit import smmgt_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  smmgt_in_if.sink   in_ch,
  smmgt_out_if.source out_ch,
  smmgt_cfg_if.sink  cfg_ch
);

  cmd_t    cmd;
  status_t sts;
  logic    in_ready;

  // Configuration is always taken.
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  // Sequencer.
  smmgt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Store, compare and result registers.
  smmgt_datapath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_new_value      (in_ch.new_value),
    .cfg_valid         (cfg_ch.valid),
    .cfg_capacity      (cfg_ch.capacity),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_add_status    (out_ch.add_status),
    .out_stored_count  (out_ch.stored_count),
    .out_span_status   (out_ch.span_status),
    .out_longest_span  (out_ch.longest_span),
    .out_shortest_span (out_ch.shortest_span)
  );

endmodule

// File: bench/span_tracker_checker.sv
// Checker for the span min/max gap tracker: predicts every result and compares it.
module span_tracker_checker import smmgt_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  smmgt_in_if   in_mon,
  smmgt_out_if  out_mon,
  smmgt_cfg_if  cfg_mon,
  output int    mismatches,
  output int    outstanding,
  output int    held_now
);
  timeunit 1ns;
  timeprecision 1ps;

  // One predicted result item.
  typedef struct packed {
    add_status_t      add_status;
    logic [CNT_W-1:0] stored_count;
    span_status_t     span_status;
    logic [VAL_W-1:0] longest_span;
    logic [VAL_W-1:0] shortest_span;
  } span_result_t;

  // Predicted state of the block; values are held with the sign bit flipped.
  logic [VAL_W-1:0] held_vals [STORE_DEPTH];
  int unsigned      held_cnt;
  logic [VAL_W-1:0] low_b;
  logic [VAL_W-1:0] high_b;
  logic [VAL_W-1:0] gap_min;
  logic [CNT_W-1:0] cap_q;
  span_result_t     span_results_q[$];

  // Add one number to the predicted set and work out the result it causes.
  function automatic span_result_t insert_value(input logic [VAL_W-1:0] raw);
    span_result_t     r;
    logic [VAL_W-1:0] b;
    logic [VAL_W-1:0] d;
    int unsigned      lim;
    int unsigned      i;
    b   = raw ^ SIGN_BIAS;
    lim = (cap_q > STORE_DEPTH) ? STORE_DEPTH : cap_q;
    r   = '0;
    if (held_cnt >= lim) begin
      r.add_status = ADD_FULL;
    end else begin
      r.add_status = ADD_STORED;
      for (i = 0; i < held_cnt; i++) begin
        d = (b >= held_vals[i]) ? b - held_vals[i] : held_vals[i] - b;
        if (d < gap_min) begin
          gap_min = d;
        end
      end
      if (held_cnt == 0) begin
        low_b  = b;
        high_b = b;
      end else begin
        if (b < low_b) begin
          low_b = b;
        end
        if (b > high_b) begin
          high_b = b;
        end
      end
      held_vals[held_cnt] = b;
      held_cnt++;
    end
    r.stored_count = held_cnt[CNT_W-1:0];
    // Spans are only meaningful once two numbers are held.
    if (held_cnt == 0) begin
      r.span_status = SPAN_NONE;
    end else if (held_cnt == 1) begin
      r.span_status = SPAN_ONE;
    end else begin
      r.span_status   = SPAN_VALID;
      r.longest_span  = high_b - low_b;
      r.shortest_span = gap_min;
    end
    return r;
  endfunction

  task automatic check_field(input string field, input logic [VAL_W-1:0] want,
                             input logic [VAL_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  // Watch all three channels at the rising edge.
  always @(posedge clk) begin
    span_result_t want;
    if (!rst_n) begin
      held_cnt   = 0;
      low_b      = '0;
      high_b     = '0;
      gap_min    = '1;
      cap_q      = '0;
      mismatches = 0;
      span_results_q.delete();
    end else begin
      // An accepted result is checked against the oldest prediction.
      if (out_mon.valid && out_mon.ready) begin
        if (span_results_q.size() == 0) begin
          mismatches++;
          $display("%0t: result mismatch, expected none, actual count %0d status %0d",
                   $time, out_mon.stored_count, out_mon.add_status);
        end else begin
          want = span_results_q.pop_front();
          check_field("add_status", VAL_W'(want.add_status), VAL_W'(out_mon.add_status));
          check_field("stored_count", VAL_W'(want.stored_count),
                      VAL_W'(out_mon.stored_count));
          check_field("span_status", VAL_W'(want.span_status),
                      VAL_W'(out_mon.span_status));
          check_field("longest_span", want.longest_span, out_mon.longest_span);
          check_field("shortest_span", want.shortest_span, out_mon.shortest_span);
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        cap_q = cfg_mon.capacity;
      end
      if (in_mon.valid && in_mon.ready) begin
        span_results_q = {span_results_q, insert_value(in_mon.new_value)};
      end
    end
    outstanding = span_results_q.size();
    held_now    = held_cnt;
  end

endmodule

// File: bench/testbench.sv
// Testbench top for the span min/max gap tracker: clock, reset, stimulus and verdict.
module testbench import smmgt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  CLK_PERIOD  = 4;
  localparam int  CYCLE_LIMIT = 1_500_000;
  localparam int  RANDOM_ITEMS = 430;
  localparam int  MAX_CAPACITY = 2047;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_BLOCKS
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  int mismatches;
  int outstanding;
  int held_now;
  int unsigned cycle_count = 0;

  smmgt_in_if  in_bus ();
  smmgt_out_if out_bus ();
  smmgt_cfg_if cfg_bus ();

  span_min_max_gap_tracker_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  span_tracker_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_bus),
    .out_mon     (out_bus),
    .cfg_mon     (cfg_bus),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .held_now    (held_now)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result receiver: segments of free flow, coin-flip stalls and long stall blocks.
  rx_mode_t    rx_mode = RX_OPEN;
  int unsigned rx_seg_left = 0;
  int unsigned rx_hold_left = 0;

  always @(negedge clk) begin
    if (rx_seg_left == 0) begin
      rx_seg_left = $urandom_range(32, 200);
      rx_mode     = rx_mode_t'($urandom_range(0, 2));
    end else begin
      rx_seg_left--;
    end
    case (rx_mode)
      RX_OPEN: begin
        out_bus.ready <= 1'b1;
      end
      RX_COIN: begin
        out_bus.ready <= 1'($urandom_range(0, 1));
      end
      default: begin
        if (rx_hold_left != 0) begin
          rx_hold_left--;
          out_bus.ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          rx_hold_left = $urandom_range(1, 20);
          out_bus.ready <= 1'b0;
        end else begin
          out_bus.ready <= 1'b1;
        end
      end
    endcase
  end

  // Offer one number and hold it until the block takes it.
  task automatic push_value(input logic [VAL_W-1:0] v);
    in_bus.valid     <= 1'b1;
    in_bus.new_value <= v;
    @(posedge clk);
    while (!in_bus.ready) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic idle_for(input int unsigned n);
    in_bus.valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic drain();
    in_bus.valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (outstanding != 0);
  endtask

  // Capacity is only written while the block is idle.
  task automatic set_capacity(input int unsigned cap);
    drain();
    cfg_bus.valid    <= 1'b1;
    cfg_bus.capacity <= CNT_W'(cap);
    @(posedge clk);
    while (!cfg_bus.ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [VAL_W-1:0] history[$];
    logic [VAL_W-1:0] v;
    logic [VAL_W-1:0] spread;
    logic [VAL_W-1:0] center;
    int unsigned      sent;
    int unsigned      rnd;
    int unsigned      extra;
    int unsigned      n;
    int unsigned      burst_left;
    int unsigned      pick;
    int unsigned      cap;
    bit               no_gaps;

    in_bus.valid     = 1'b0;
    in_bus.new_value = '0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.capacity = '0;
    rst_n            = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Zero capacity: everything is rejected and nothing is stored.
    set_capacity(0);
    push_value(32'h7FFF_FFFF);
    push_value(32'h8000_0000);
    push_value(0);
    // A single stored number, then a full store.
    set_capacity(1);
    push_value(1000);
    push_value(-5);
    // A few numbers with known spans.
    set_capacity(4);
    push_value(-2000);
    push_value(2500);
    push_value(1010);
    // Capacity lowered below the count keeps the block full.
    set_capacity(2);
    push_value(7);

    // Random rounds; the spread of values shrinks so the shortest span keeps moving.
    sent = 0;
    rnd  = 0;
    while (sent < RANDOM_ITEMS) begin
      drain();
      extra = $urandom_range(8, 48);
      if (rnd % 5 == 4) begin
        cap = $urandom_range(0, held_now);
        n   = $urandom_range(2, 5);
      end else if (rnd == 6) begin
        cap = MAX_CAPACITY;
        n   = extra;
      end else begin
        cap = held_now + extra;
        n   = extra + $urandom_range(0, 6);
      end
      set_capacity(cap);
      spread     = 32'hFFFF_FFFF >> (2 * ((rnd < 15) ? rnd : 15));
      center     = $urandom();
      no_gaps    = ($urandom_range(0, 3) == 0);
      burst_left = $urandom_range(1, 12);
      for (int unsigned k = 0; k < n; k++) begin
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          v = $urandom();
        end else if (pick < 9) begin
          v = center + $urandom_range(0, spread) - (spread >> 1);
        end else if (rnd >= 12 && history.size() != 0) begin
          v = history[$urandom_range(0, history.size() - 1)];
        end else if ($urandom_range(0, 1) == 1) begin
          v = 32'h7FFF_FFFF - $urandom_range(0, 15);
        end else begin
          v = 32'h8000_0000 + $urandom_range(0, 15);
        end
        push_value(v);
        history = {history, v};
        sent++;
        // Let the pipe empty once in the middle of a round.
        if (rnd == 3 && k == n / 2) begin
          drain();
        end else if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          if (!no_gaps) begin
            idle_for($urandom_range(1, 6));
          end
        end else begin
          burst_left--;
        end
      end
      rnd++;
    end

    // Extreme values, then a repeat that drives the shortest span to zero.
    set_capacity(MAX_CAPACITY);
    push_value(32'h7FFF_FFFF);
    push_value(32'h8000_0000);
    push_value(0);
    push_value(32'hFFFF_FFFF);
    push_value(32'h7FFF_FFFF);
    set_capacity(STORE_DEPTH_DEF);
    push_value(12345);
    // Capacity exactly at the count.
    drain();
    set_capacity(held_now);
    push_value(1);

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
